[src/i2cram_pkg.sv]
// shared types and constants for the i2c register access master
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

    localparam int BYTE_COUNT_W  = 9;
    localparam int MAX_BYTES_DEF = 256;
    localparam int REG_ADDR_W    = 11;
    localparam int BIT_IDX_W     = 4;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_BYTE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        K_ADDR1 = 2'd0,
        K_REG   = 2'd1,
        K_ADDR2 = 2'd2,
        K_DATA  = 2'd3
    } kind_t;

    typedef enum logic [15:0] {
        PH_IDLE = 16'h0001,
        PH_S1   = 16'h0002,
        PH_S2   = 16'h0004,
        PH_S3   = 16'h0008,
        PH_R1   = 16'h0010,
        PH_R2   = 16'h0020,
        PH_R3   = 16'h0040,
        PH_TXLO = 16'h0080,
        PH_TXHI = 16'h0100,
        PH_RXLO = 16'h0200,
        PH_RXHI = 16'h0400,
        PH_MALO = 16'h0800,
        PH_MAHI = 16'h1000,
        PH_WAIT = 16'h2000,
        PH_P1   = 16'h4000,
        PH_P2   = 16'h8000
    } phase_t;

    typedef struct packed {
        action_t                   action;
        logic [REG_ADDR_W-1:0]     reg_addr;
        logic [BYTE_COUNT_W-1:0]   byte_count;
        logic [7:0]                data_byte;
        logic                      sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic       need_byte;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
    } res_t;

endpackage

`default_nettype wire

[src/i2cram_core.sv]
// bus phase sequencer: state registers and one-step next-state and result logic
`timescale 1ns / 1ps
`default_nettype none

module i2cram_core
    import i2cram_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       step,
    input  wire req_t       req,
    output res_t            res
);

    localparam int BL_W  = $clog2(MAX_BYTES + 1);
    localparam int CMP_W = (BL_W > BYTE_COUNT_W) ? BL_W : BYTE_COUNT_W;

    logic [7:0]            dev_addr_reg;
    phase_t                phase_reg, phase_next;
    kind_t                 kind_reg, kind_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [BL_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  ack_all_reg, ack_all_next;
    logic                  is_read_reg, is_read_next;
    logic [REG_ADDR_W-1:0] saved_addr_reg, saved_addr_next;
    logic [7:0]            hold_byte_reg, hold_byte_next;
    logic                  hold_valid_reg, hold_valid_next;

    logic                  rx_valid, rx_last, done, ack_out;
    logic [7:0]            rx_shift;
    logic [BIT_IDX_W-1:0]  rx_bit;
    logic [7:0]            addr_wr, addr_rd;
    logic                  scl, rel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= K_ADDR1;
            bit_idx_reg    <= '0;
            bytes_left_reg <= '0;
            shift_reg      <= '0;
            ack_all_reg    <= 1'b1;
            is_read_reg    <= 1'b0;
            saved_addr_reg <= '0;
            hold_byte_reg  <= '0;
            hold_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            bit_idx_reg    <= bit_idx_next;
            bytes_left_reg <= bytes_left_next;
            shift_reg      <= shift_next;
            ack_all_reg    <= ack_all_next;
            is_read_reg    <= is_read_next;
            saved_addr_reg <= saved_addr_next;
            hold_byte_reg  <= hold_byte_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    assign addr_wr = dev_addr_reg | {4'b0000, saved_addr_reg[10:8], 1'b0};
    assign addr_rd = addr_wr | 8'h01;
    assign rx_shift = {shift_reg[6:0], req.sda_in};
    assign rx_bit   = bit_idx_reg + BIT_IDX_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        bit_idx_next    = bit_idx_reg;
        bytes_left_next = bytes_left_reg;
        shift_next      = shift_reg;
        ack_all_next    = ack_all_reg;
        is_read_next    = is_read_reg;
        saved_addr_next = saved_addr_reg;
        hold_byte_next  = hold_byte_reg;
        hold_valid_next = hold_valid_reg;
        rx_valid        = 1'b0;
        rx_last         = 1'b0;
        done            = 1'b0;

        unique case (req.action)
            ACT_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_S1: phase_next = PH_S2;
                    PH_S2: phase_next = PH_S3;
                    PH_S3:
                    begin
                        shift_next   = addr_wr;
                        bit_idx_next = '0;
                        kind_next    = K_ADDR1;
                        phase_next   = PH_TXLO;
                    end
                    PH_R1: phase_next = PH_R2;
                    PH_R2: phase_next = PH_R3;
                    PH_R3:
                    begin
                        shift_next   = addr_rd;
                        bit_idx_next = '0;
                        kind_next    = K_ADDR2;
                        phase_next   = PH_TXLO;
                    end
                    PH_TXLO: phase_next = PH_TXHI;
                    PH_TXHI:
                    begin
                        if (bit_idx_reg < BIT_IDX_W'(8))
                        begin
                            bit_idx_next = rx_bit;
                            phase_next   = PH_TXLO;
                        end
                        else
                        begin
                            ack_all_next = ack_all_reg & ~req.sda_in;
                            unique case (kind_reg)
                                K_ADDR1:
                                begin
                                    shift_next   = saved_addr_reg[7:0];
                                    bit_idx_next = '0;
                                    kind_next    = K_REG;
                                    phase_next   = PH_TXLO;
                                end
                                K_ADDR2:
                                begin
                                    if (bytes_left_reg == '0)
                                    begin
                                        phase_next = PH_P1;
                                    end
                                    else
                                    begin
                                        shift_next   = '0;
                                        bit_idx_next = '0;
                                        phase_next   = PH_RXLO;
                                    end
                                end
                                K_REG, K_DATA:
                                begin
                                    if (kind_reg == K_REG && is_read_reg)
                                    begin
                                        phase_next = PH_R1;
                                    end
                                    else if (bytes_left_reg == '0)
                                    begin
                                        phase_next = PH_P1;
                                    end
                                    else if (hold_valid_reg)
                                    begin
                                        hold_valid_next = 1'b0;
                                        bytes_left_next = bytes_left_reg - BL_W'(1);
                                        shift_next      = hold_byte_reg;
                                        bit_idx_next    = '0;
                                        kind_next       = K_DATA;
                                        phase_next      = PH_TXLO;
                                    end
                                    else
                                    begin
                                        phase_next = PH_WAIT;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    PH_RXLO: phase_next = PH_RXHI;
                    PH_RXHI:
                    begin
                        shift_next   = rx_shift;
                        bit_idx_next = rx_bit;
                        if (rx_bit >= BIT_IDX_W'(8))
                        begin
                            rx_valid = 1'b1;
                            rx_last  = (bytes_left_reg == BL_W'(1));
                            if (bytes_left_reg != '0)
                            begin
                                bytes_left_next = bytes_left_reg - BL_W'(1);
                            end
                            phase_next = PH_MALO;
                        end
                        else
                        begin
                            phase_next = PH_RXLO;
                        end
                    end
                    PH_MALO: phase_next = PH_MAHI;
                    PH_MAHI:
                    begin
                        if (bytes_left_reg == '0)
                        begin
                            phase_next = PH_P1;
                        end
                        else
                        begin
                            shift_next   = '0;
                            bit_idx_next = '0;
                            phase_next   = PH_RXLO;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (bytes_left_reg == '0)
                        begin
                            phase_next = PH_P1;
                        end
                        else if (hold_valid_reg)
                        begin
                            hold_valid_next = 1'b0;
                            bytes_left_next = bytes_left_reg - BL_W'(1);
                            shift_next      = hold_byte_reg;
                            bit_idx_next    = '0;
                            kind_next       = K_DATA;
                            phase_next      = PH_TXLO;
                        end
                    end
                    PH_P1: phase_next = PH_P2;
                    PH_P2:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            ACT_BYTE:
            begin
                if (phase_reg != PH_IDLE && !is_read_reg && bytes_left_reg != '0
                    && !hold_valid_reg)
                begin
                    hold_byte_next  = req.data_byte;
                    hold_valid_next = 1'b1;
                end
            end
            ACT_WRITE, ACT_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_read_next    = (req.action == ACT_READ);
                    saved_addr_next = req.reg_addr;
                    if (CMP_W'(req.byte_count) > CMP_W'(MAX_BYTES))
                    begin
                        bytes_left_next = BL_W'(MAX_BYTES);
                    end
                    else
                    begin
                        bytes_left_next = BL_W'(req.byte_count);
                    end
                    ack_all_next    = 1'b1;
                    hold_valid_next = 1'b0;
                    bit_idx_next    = '0;
                    phase_next      = PH_S1;
                end
            end
            default: ;
        endcase
    end

    assign ack_out = done & ack_all_next;

    // bus levels after the step
    always_comb
    begin
        scl = 1'b1;
        rel = 1'b1;
        unique case (phase_next)
            PH_TXLO, PH_TXHI:
            begin
                scl = (phase_next == PH_TXHI);
                rel = (bit_idx_next < BIT_IDX_W'(8)) ? shift_next[~bit_idx_next[2:0]] : 1'b1;
            end
            PH_S1, PH_R1:     begin scl = 1'b1; rel = 1'b1; end
            PH_S2, PH_R2:     begin scl = 1'b1; rel = 1'b0; end
            PH_S3, PH_R3:     begin scl = 1'b0; rel = 1'b0; end
            PH_RXLO:          begin scl = 1'b0; rel = 1'b1; end
            PH_RXHI:          begin scl = 1'b1; rel = 1'b1; end
            PH_MALO:          begin scl = 1'b0; rel = (bytes_left_next == '0); end
            PH_MAHI:          begin scl = 1'b1; rel = (bytes_left_next == '0); end
            PH_WAIT:          begin scl = 1'b0; rel = 1'b1; end
            PH_P1:            begin scl = 1'b0; rel = 1'b0; end
            PH_P2:            begin scl = 1'b1; rel = 1'b0; end
            default:          begin scl = 1'b1; rel = 1'b1; end
        endcase
    end

    always_comb
    begin
        res.scl         = scl;
        res.sda_release = rel;
        res.busy_res    = (phase_next != PH_IDLE);
        res.need_byte   = (phase_next != PH_IDLE) && !is_read_next
                          && (bytes_left_next != '0) && !hold_valid_next;
        res.rx_byte     = rx_valid ? shift_next : 8'h00;
        res.rx_valid    = rx_valid;
        res.rx_last     = rx_last;
        res.done_res    = done;
        res.ack_ok      = ack_out;
    end

endmodule

`default_nettype wire

[src/i2c_register_access_master_unit.sv]
// top level: request register, phase sequencer and result register
//
// channel   dir  tdata                                          tuser    tlast
// s_axis    in   reg_addr, byte_count, data_byte, sda_in        action   -
// m_axis    out  scl, sda_release, need_byte, rx_byte,          -        rx_last
//                rx_valid, busy_res, done_res, ack_ok
// cfg       in   cfg_wr_data = device_addr_byte, cfg_wr_en
//
// one request per cycle unless m stalls; one result per request, held in out_reg
// the sequencer state moves when the request register hands its request on
// a stalled m side holds the result register; one more request waits in the
// request register, then s_tready drops
// rst_n clears the phase and control state at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master_unit
    import i2cram_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [10:0] reg_addr, [19:11] byte_count, [27:20] data_byte, [28] sda_in
    input  wire logic [31:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] scl, [1] sda_release, [2] need_byte, [10:3] rx_byte, [11] rx_valid,
    // [12] busy_res, [13] done_res, [14] ack_ok
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    logic  req_valid_reg;
    req_t  req_reg;
    logic  out_valid_reg;
    res_t  out_reg;
    res_t  res;
    logic  advance;
    logic  step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = req_valid_reg && advance;
    assign s_tready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg.action     <= action_t'(s_tuser);
            req_reg.reg_addr   <= s_tdata[10:0];
            req_reg.byte_count <= s_tdata[19:11];
            req_reg.data_byte  <= s_tdata[27:20];
            req_reg.sda_in     <= s_tdata[28];
        end
    end

    i2cram_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .req         (req_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.rx_last;
    assign m_tdata  = {1'b0, out_reg.ack_ok, out_reg.done_res, out_reg.busy_res,
                       out_reg.rx_valid, out_reg.rx_byte, out_reg.need_byte,
                       out_reg.sda_release, out_reg.scl};

endmodule

`default_nettype wire

[verif/i2c_register_access_master_unit_tb.sv]
// testbench for the i2c register access master: predicted bus steps checked against each result
`timescale 1ns / 1ps

module i2c_register_access_master_unit_tb;
    import i2cram_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    i2c_register_access_master_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted master state
    logic [7:0]  bus_dev_addr;
    phase_t      bus_phase;
    kind_t       bus_kind;
    logic [3:0]  bus_bit;
    logic [8:0]  bus_left;
    logic [7:0]  bus_shift;
    logic        bus_ack_all;
    logic        bus_rd;
    logic [10:0] bus_addr;
    logic [7:0]  bus_hold;
    logic        bus_hold_v;

    res_t awaited_bus_out[$];
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   send_idle_max = 15;
    int   recv_idle_max = 15;

    function automatic void reset_bus();
        bus_dev_addr = 8'h00;
        bus_phase    = PH_IDLE;
        bus_kind     = K_ADDR1;
        bus_bit      = '0;
        bus_left     = '0;
        bus_shift    = '0;
        bus_ack_all  = 1'b1;
        bus_rd       = 1'b0;
        bus_addr     = '0;
        bus_hold     = '0;
        bus_hold_v   = 1'b0;
    endfunction

    function automatic logic [7:0] addr_octet(logic rd);
        return bus_dev_addr | {4'b0000, bus_addr[10:8], 1'b0} | {7'b0000000, rd};
    endfunction

    function automatic logic byte_wanted();
        return bus_phase != PH_IDLE && !bus_rd && bus_left != 0 && !bus_hold_v;
    endfunction

    function automatic void load_octet(kind_t k, logic [7:0] b);
        bus_shift = b;
        bus_bit   = '0;
        bus_kind  = k;
        bus_phase = PH_TXLO;
    endfunction

    function automatic void next_data_octet();
        if (bus_left == 0)
            bus_phase = PH_P1;
        else if (bus_hold_v)
        begin
            bus_hold_v = 1'b0;
            bus_left   = bus_left - 9'd1;
            load_octet(K_DATA, bus_hold);
        end
        else
            bus_phase = PH_WAIT;
    endfunction

    function automatic void start_rx_octet();
        bus_shift = '0;
        bus_bit   = '0;
        bus_phase = PH_RXLO;
    endfunction

    function automatic void clock_bus(logic sda, inout res_t r);
        case (bus_phase)
            PH_TXLO: bus_phase = PH_TXHI;
            PH_TXHI:
            begin
                if (bus_bit < 4'd8)
                begin
                    bus_bit   = bus_bit + 4'd1;
                    bus_phase = PH_TXLO;
                end
                else
                begin
                    bus_ack_all = bus_ack_all & ~sda;
                    case (bus_kind)
                        K_ADDR1: load_octet(K_REG, bus_addr[7:0]);
                        K_REG:
                        begin
                            if (bus_rd)
                                bus_phase = PH_R1;
                            else
                                next_data_octet();
                        end
                        K_ADDR2:
                        begin
                            if (bus_left == 0)
                                bus_phase = PH_P1;
                            else
                                start_rx_octet();
                        end
                        default: next_data_octet();
                    endcase
                end
            end
            PH_S1: bus_phase = PH_S2;
            PH_S2: bus_phase = PH_S3;
            PH_S3: load_octet(K_ADDR1, addr_octet(1'b0));
            PH_R1: bus_phase = PH_R2;
            PH_R2: bus_phase = PH_R3;
            PH_R3: load_octet(K_ADDR2, addr_octet(1'b1));
            PH_RXLO: bus_phase = PH_RXHI;
            PH_RXHI:
            begin
                bus_shift = {bus_shift[6:0], sda};
                bus_bit   = bus_bit + 4'd1;
                if (bus_bit >= 4'd8)
                begin
                    r.rx_byte  = bus_shift;
                    r.rx_valid = 1'b1;
                    r.rx_last  = (bus_left == 9'd1);
                    if (bus_left > 0)
                        bus_left = bus_left - 9'd1;
                    bus_phase = PH_MALO;
                end
                else
                    bus_phase = PH_RXLO;
            end
            PH_MALO: bus_phase = PH_MAHI;
            PH_MAHI:
            begin
                if (bus_left == 0)
                    bus_phase = PH_P1;
                else
                    start_rx_octet();
            end
            PH_WAIT: next_data_octet();
            PH_P1: bus_phase = PH_P2;
            PH_P2:
            begin
                bus_phase = PH_IDLE;
                r.done_res = 1'b1;
                r.ack_ok   = bus_ack_all;
            end
            default: bus_phase = PH_IDLE;
        endcase
    endfunction

    function automatic res_t step_bus(action_t act, logic [10:0] ra, logic [8:0] cnt,
                                      logic [7:0] db, logic sda);
        res_t r;
        r = '0;
        case (act)
            ACT_TICK:
            begin
                if (bus_phase != PH_IDLE)
                    clock_bus(sda, r);
            end
            ACT_BYTE:
            begin
                if (byte_wanted())
                begin
                    bus_hold   = db;
                    bus_hold_v = 1'b1;
                end
            end
            default:
            begin
                if (bus_phase == PH_IDLE)
                begin
                    bus_rd      = (act == ACT_READ);
                    bus_addr    = ra;
                    bus_left    = (cnt > MAX_BYTES_DEF) ? 9'(MAX_BYTES_DEF) : cnt;
                    bus_ack_all = 1'b1;
                    bus_hold_v  = 1'b0;
                    bus_bit     = '0;
                    bus_phase   = PH_S1;
                end
            end
        endcase

        case (bus_phase)
            PH_TXLO, PH_TXHI:
            begin
                r.scl         = (bus_phase == PH_TXHI);
                r.sda_release = (bus_bit < 4'd8) ? bus_shift[4'd7 - bus_bit] : 1'b1;
            end
            PH_S1, PH_R1:     begin r.scl = 1'b1; r.sda_release = 1'b1; end
            PH_S2, PH_R2:     begin r.scl = 1'b1; r.sda_release = 1'b0; end
            PH_S3, PH_R3:     begin r.scl = 1'b0; r.sda_release = 1'b0; end
            PH_RXLO, PH_WAIT: begin r.scl = 1'b0; r.sda_release = 1'b1; end
            PH_RXHI:          begin r.scl = 1'b1; r.sda_release = 1'b1; end
            PH_MALO:          begin r.scl = 1'b0; r.sda_release = (bus_left == 0); end
            PH_MAHI:          begin r.scl = 1'b1; r.sda_release = (bus_left == 0); end
            PH_P1:            begin r.scl = 1'b0; r.sda_release = 1'b0; end
            PH_P2:            begin r.scl = 1'b1; r.sda_release = 1'b0; end
            default:          begin r.scl = 1'b1; r.sda_release = 1'b1; end
        endcase
        r.busy_res  = (bus_phase != PH_IDLE);
        r.need_byte = byte_wanted();
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.scl         = m_tdata[0];
            got.sda_release = m_tdata[1];
            got.need_byte   = m_tdata[2];
            got.rx_byte     = m_tdata[10:3];
            got.rx_valid    = m_tdata[11];
            got.busy_res    = m_tdata[12];
            got.done_res    = m_tdata[13];
            got.ack_ok      = m_tdata[14];
            got.rx_last     = m_tlast;
            if (awaited_bus_out.size() == 0)
                report_mismatch("result with nothing awaited");
            else
            begin
                want = awaited_bus_out.pop_front();
                check_field("scl", int'(got.scl), int'(want.scl));
                check_field("sda_release", int'(got.sda_release), int'(want.sda_release));
                check_field("need_byte", int'(got.need_byte), int'(want.need_byte));
                check_field("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
                check_field("rx_valid", int'(got.rx_valid), int'(want.rx_valid));
                check_field("rx_last", int'(got.rx_last), int'(want.rx_last));
                check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
                check_field("done_res", int'(got.done_res), int'(want.done_res));
                check_field("ack_ok", int'(got.ack_ok), int'(want.ack_ok));
            end
        end
    end

    // result side back-pressure
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic push_request(action_t act, logic [10:0] ra, logic [8:0] cnt,
                                logic [7:0] db, logic sda);
        int gap;
        gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sda, db, cnt, ra};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        awaited_bus_out.push_back(step_bus(act, ra, cnt, db, sda));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_bus_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [7:0] v);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        bus_dev_addr = v;
    endtask

    // one whole transaction; ticks until the master is idle again
    task automatic run_txn(logic rd, logic [10:0] ra, logic [8:0] cnt, int nack_pct,
                           int late_pct, int noise_pct, logic pause);
        int      steps;
        logic    sda;
        action_t noise_act;
        steps = 0;
        push_request(rd ? ACT_READ : ACT_WRITE, ra, cnt, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        while (bus_phase != PH_IDLE)
        begin
            steps++;
            if (pause && steps == 7)
                wait_drained();
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0:       noise_act = ACT_WRITE;
                    1:       noise_act = ACT_READ;
                    default: noise_act = ACT_BYTE;
                endcase
                push_request(noise_act, 11'($urandom_range(0, 2047)),
                             9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
            else if (byte_wanted() && $urandom_range(0, 99) >= late_pct)
                push_request(ACT_BYTE, 11'($urandom_range(0, 2047)),
                             9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            else
            begin
                if (bus_phase == PH_TXHI && bus_bit == 4'd8)
                    sda = ($urandom_range(0, 99) < nack_pct);
                else
                    sda = 1'($urandom_range(0, 1));
                push_request(ACT_TICK, 11'($urandom_range(0, 2047)),
                             9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)), sda);
            end
        end
    endtask

    task automatic test_idle_bus();
        push_request(ACT_TICK, 11'h000, 9'h000, 8'h00, 1'b0);
        push_request(ACT_TICK, 11'h7FF, 9'h1FF, 8'hFF, 1'b1);
        push_request(ACT_BYTE, 11'h7FF, 9'h1FF, 8'hFF, 1'b1);
        push_request(ACT_BYTE, 11'h000, 9'h000, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_address_extremes();
        write_config(8'h00);
        run_txn(1'b0, 11'h000, 9'd0, 0, 0, 0, 1'b0);
        write_config(8'hFE);
        run_txn(1'b0, 11'h7FF, 9'd1, 0, 0, 0, 1'b0);
        // bit zero of the base address set
        write_config(8'hFF);
        run_txn(1'b1, 11'h7FF, 9'd1, 0, 0, 0, 1'b0);
        write_config(8'h01);
        run_txn(1'b1, 11'h500, 9'd0, 0, 0, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_write_paths();
        write_config(8'hA0);
        run_txn(1'b0, 11'h123, 9'd1, 0, 0, 0, 1'b0);
        // byte supplied late, master parks in wait
        run_txn(1'b0, 11'h3C5, 9'd2, 0, 95, 0, 1'b0);
        run_txn(1'b0, 11'h0AA, 9'd2, 100, 0, 0, 1'b0);
        // begins while busy and unwanted bytes are ignored
        run_txn(1'b0, 11'h655, 9'd3, 0, 50, 30, 1'b0);
        wait_drained();
    endtask

    task automatic test_read_paths();
        run_txn(1'b1, 11'h2F0, 9'd0, 0, 0, 0, 1'b0);
        run_txn(1'b1, 11'h10F, 9'd1, 0, 0, 0, 1'b0);
        run_txn(1'b1, 11'h7A5, 9'd3, 100, 0, 20, 1'b0);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        run_txn(1'b0, 11'h222, 9'd2, 0, 30, 0, 1'b1);
        run_txn(1'b1, 11'h333, 9'd2, 0, 0, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int         start;
        int         n_txn;
        logic [8:0] cnt;
        start = items_sent;
        n_txn = 0;
        while (items_sent - start < 300)
        begin
            if (n_txn % 2 == 0)
            begin
                send_idle_max = $urandom_range(0, 1) ? 15 : 0;
                recv_idle_max = $urandom_range(0, 1) ? 15 : 0;
            end
            if (n_txn % 4 == 3)
                write_config(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
                push_request($urandom_range(0, 1) ? ACT_TICK : ACT_BYTE,
                             11'($urandom_range(0, 2047)), 9'($urandom_range(0, 511)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            cnt = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(5, 20))
                                              : 9'($urandom_range(0, 4));
            run_txn(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)), cnt,
                    ($urandom_range(0, 5) == 0) ? 30 : 0, $urandom_range(0, 3) * 30,
                    ($urandom_range(0, 3) == 0) ? 5 : 0, 1'b0);
            n_txn++;
        end
        wait_drained();
    endtask

    initial
    begin
        reset_bus();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_bus();
        test_address_extremes();
        test_write_paths();
        test_read_paths();
        test_sender_pause();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
